// File: sv/bfdh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bfdh_pkg;

  localparam int DEF_MAX_BITS   = 65536;
  localparam int DEF_MAX_HASHES = 32;

  localparam int CMD_W      = 2;
  localparam int HASH_W     = 16;
  localparam int FBITS_W    = 17;
  localparam int HCOUNT_W   = 6;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 17;
  localparam int ROW_W      = 32;
  localparam int COL_W      = $clog2(ROW_W);

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_STORE_BITS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT = 8'd1;

  localparam logic [FBITS_W-1:0]  FBITS_RESET  = 17'd65536;
  localparam logic [HCOUNT_W-1:0] HCOUNT_RESET = 6'd7;

  typedef struct packed {
    logic idle;
    logic load;
    logic probe;
    logic sweep;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic has_probes;
    logic probe_last;
    logic sweep_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: sv/bfdh_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bfdh_cfg_if import bfdh_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/bfdh_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bfdh_in_if import bfdh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [HASH_W-1:0] first_hash;
  logic [HASH_W-1:0] second_hash;

  modport source (output valid, cmd, first_hash, second_hash, input ready);
  modport sink (input valid, cmd, first_hash, second_hash, output ready);
endinterface

`default_nettype wire

// File: sv/bfdh_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bfdh_out_if import bfdh_pkg::*; ();
  logic valid;
  logic ready;
  logic present;
  logic range_error;

  modport source (output valid, present, range_error, input ready);
  modport sink (input valid, present, range_error, output ready);
endinterface

`default_nettype wire

// File: sv/bloom_filter_double_hash.sv
// Channel   Port    Direction  Contents
// config    cfg_ch  in         index, data (0 store size in bits, 1 hash count)
// request   in_ch   in         cmd, first_hash, second_hash
// result    out_ch  out        present, range_error
//
// Insert and query issue hash_count probes, one per cycle, on the single
// port of the bit store. A range error, an unused command or no probes goes
// from load straight to the finish state. Clear sweeps the store one 32-bit
// row per cycle. After reset the same sweep runs once before the first
// request is taken. A stalled result stays in the output register and the
// next request is finished only once it leaves.
`timescale 1ns / 1ps
`default_nettype none

module bloom_filter_double_hash import bfdh_pkg::*; #(
  parameter int MAX_BITS   = DEF_MAX_BITS,
  parameter int MAX_HASHES = DEF_MAX_HASHES
) (
  input logic        clk,
  input logic        rst_n,
  bfdh_cfg_if.sink   cfg_ch,
  bfdh_in_if.sink    in_ch,
  bfdh_out_if.source out_ch
);

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;
  logic     out_valid;
  logic     out_present;
  logic     out_range_error;

  bfdh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .stat     (dp_stat),
    .cmd      (ctl_cmd)
  );

  bfdh_dp #(
    .MAX_BITS   (MAX_BITS),
    .MAX_HASHES (MAX_HASHES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_ch.valid),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .in_cmd          (in_ch.cmd),
    .in_first_hash   (in_ch.first_hash),
    .in_second_hash  (in_ch.second_hash),
    .cmd             (ctl_cmd),
    .stat            (dp_stat),
    .out_ready       (out_ch.ready),
    .out_valid       (out_valid),
    .out_present     (out_present),
    .out_range_error (out_range_error)
  );

  assign cfg_ch.ready       = 1'b1;
  assign in_ch.ready        = ctl_cmd.idle;
  assign out_ch.valid       = out_valid;
  assign out_ch.present     = out_present;
  assign out_ch.range_error = out_range_error;

  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request taken on consecutive cycles");

  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl_cmd.load, ctl_cmd.probe, ctl_cmd.sweep, ctl_cmd.finish}))
    else $error("controller issued overlapping actions");

  a_init_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ch.ready)
    else $error("request taken before the store was cleared");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(ctl_cmd.finish))
    else $error("result appeared without a finished request");

endmodule

`default_nettype wire

// File: sv/bfdh_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bfdh_ctrl import bfdh_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_INIT   = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_PROBE  = 5'b00100,
    ST_CLEAR  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_INIT: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.idle = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.is_clear) begin
            state_nxt = ST_CLEAR;
          end else if (stat.has_probes) begin
            state_nxt = ST_PROBE;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_PROBE: begin
        cmd.probe = 1'b1;
        if (stat.probe_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_CLEAR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/bfdh_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module bfdh_dp import bfdh_pkg::*; #(
  parameter int MAX_BITS   = DEF_MAX_BITS,
  parameter int MAX_HASHES = DEF_MAX_HASHES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [HASH_W-1:0]     in_first_hash,
  input  logic [HASH_W-1:0]     in_second_hash,
  input  ctl_cmd_t              cmd,
  output dp_stat_t              stat,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  out_present,
  output logic                  out_range_error
);

  localparam int MW   = $clog2(MAX_BITS + 1);
  localparam int IW   = (MW > COL_W + 1) ? MW : COL_W + 1;
  localparam int CW   = (MW > HASH_W) ? MW : HASH_W;
  localparam int FW   = (MW > FBITS_W) ? MW : FBITS_W;
  localparam int KW   = $clog2(MAX_HASHES + 1);
  localparam int HW   = (KW > HCOUNT_W) ? KW : HCOUNT_W;
  localparam int ROWS = (MAX_BITS + ROW_W - 1) / ROW_W;
  localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [FBITS_W-1:0]  fbits_r;
  logic [HCOUNT_W-1:0] hcount_r;

  logic [FW-1:0] fb_ext;
  logic [FW-1:0] m_full;
  logic [MW-1:0] eff_m;
  logic [HW-1:0] hc_ext;
  logic [HW-1:0] k_full;
  logic [KW-1:0] eff_k;

  logic [CW-1:0] h1_ext;
  logic [CW-1:0] h2_ext;
  logic [CW-1:0] m_ext;
  logic          probe_cmd;
  logic          range_hit;

  logic [CMD_W-1:0] cmd_r;
  logic             err_r;
  logic [MW-1:0]    m_r;
  logic [KW-1:0]    k_r;
  logic [KW-1:0]    cnt_r;
  logic [KW-1:0]    cnt_inc;
  logic [IW-1:0]    idx_r;
  logic [IW-1:0]    h2_r;
  logic             all_set_r;

  logic [IW:0]   idx_sum;
  logic [IW:0]   m_wide;
  logic [IW:0]   idx_adv_w;
  logic [IW-1:0] idx_hi;
  logic [RAW-1:0]   probe_row;
  logic [COL_W-1:0] probe_col;

  logic [RAW-1:0] sw_r;
  logic           sweep_last;
  logic [RAW-1:0] mem_addr;

  logic [ROW_W-1:0] mem_q [ROWS];
  logic [ROW_W-1:0] rdata_r;
  logic [COL_W-1:0] col_r;
  logic             chk_v_r;
  logic             bit_miss;
  logic             present_val;

  logic out_valid_r;
  logic present_r;
  logic range_error_r;
  logic out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fbits_r  <= FBITS_RESET;
      hcount_r <= HCOUNT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_STORE_BITS) begin
        fbits_r <= cfg_data[FBITS_W-1:0];
      end else if (cfg_index == REG_HASH_COUNT) begin
        hcount_r <= cfg_data[HCOUNT_W-1:0];
      end
    end
  end

  always_comb begin
    fb_ext = FW'(fbits_r);
    if (fb_ext == '0) begin
      m_full = FW'(1);
    end else if (fb_ext > FW'(MAX_BITS)) begin
      m_full = FW'(MAX_BITS);
    end else begin
      m_full = fb_ext;
    end
    eff_m = m_full[MW-1:0];

    hc_ext = HW'(hcount_r);
    k_full = (hc_ext > HW'(MAX_HASHES)) ? HW'(MAX_HASHES) : hc_ext;
    eff_k  = k_full[KW-1:0];
  end

  assign h1_ext    = CW'(in_first_hash);
  assign h2_ext    = CW'(in_second_hash);
  assign m_ext     = CW'(eff_m);
  assign probe_cmd = (in_cmd == CMD_INSERT) || (in_cmd == CMD_QUERY);
  assign range_hit = probe_cmd && ((h1_ext >= m_ext) || (h2_ext >= m_ext));

  // Next probe index: both terms are below the modulus, so one subtract wraps it.
  assign idx_sum   = {1'b0, idx_r} + {1'b0, h2_r};
  assign m_wide    = (IW + 1)'(m_r);
  assign idx_adv_w = (idx_sum >= m_wide) ? (idx_sum - m_wide) : idx_sum;
  assign cnt_inc   = cnt_r + KW'(1);

  assign idx_hi    = idx_r >> COL_W;
  assign probe_row = idx_hi[RAW-1:0];
  assign probe_col = idx_r[COL_W-1:0];

  assign sweep_last = (sw_r == RAW'(ROWS - 1));
  assign mem_addr   = cmd.sweep ? sw_r : probe_row;

  assign bit_miss    = chk_v_r && !rdata_r[col_r];
  assign present_val = (cmd_r == CMD_QUERY) && !err_r && all_set_r && !bit_miss;
  assign out_free    = !out_valid_r || out_ready;

  always_comb begin
    stat            = '0;
    stat.is_clear   = (in_cmd == CMD_CLEAR);
    stat.has_probes = probe_cmd && !range_hit && (eff_k != '0);
    stat.probe_last = (cnt_inc == k_r);
    stat.sweep_last = sweep_last;
    stat.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_cmd;
      err_r <= range_hit;
      m_r   <= eff_m;
      k_r   <= eff_k;
      cnt_r <= '0;
      idx_r <= h1_ext[IW-1:0];
      h2_r  <= h2_ext[IW-1:0];
    end else if (cmd.probe) begin
      cnt_r <= cnt_inc;
      idx_r <= idx_adv_w[IW-1:0];
    end
    if (cmd.load) begin
      all_set_r <= 1'b1;
    end else if (bit_miss) begin
      all_set_r <= 1'b0;
    end
    col_r <= probe_col;
    if (cmd.finish) begin
      present_r     <= present_val;
      range_error_r <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      mem_q[mem_addr] <= '0;
    end else if (cmd.probe && (cmd_r == CMD_INSERT)) begin
      mem_q[mem_addr][probe_col] <= 1'b1;
    end
    rdata_r <= mem_q[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r        <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.sweep) begin
        sw_r <= sweep_last ? '0 : sw_r + RAW'(1);
      end
      chk_v_r <= cmd.probe && (cmd_r == CMD_QUERY);
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_present     = present_r;
  assign out_range_error = range_error_r;

endmodule

`default_nettype wire
